FILE: sv/mipf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipf_pkg: shared definitions for the modular inverse core
// Word width, sequencer states and the control/status bundles passed
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package mipf_pkg;

    // Datapath word width; operand and modulus are taken at this width
    localparam int WORD_BITS  = 16;
    // Width of the external operand, result and modulus ports
    localparam int FIELD_BITS = 16;
    // Shift count covers 0..WORD_BITS-1
    localparam int CNT_BITS   = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    localparam logic [FIELD_BITS-1:0] FIELD_ORDER_RESET = FIELD_BITS'(7);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_SUB,
        ST_FINISH
    } state_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic rc_zero;    // current remainder is zero: Euclid loop done
        logic can_shift;  // divisor can be doubled without passing dividend
        logic k_zero;     // last quotient bit in progress
    } stat_t;

    // Sequencer commands to the datapath
    typedef struct packed {
        logic load;       // take a new operand
        logic align;      // compare doubled divisor against dividend
        logic shift_up;   // double divisor and coefficient step
        logic sub_step;   // one restoring quotient bit
        logic swap;       // end of one division: rotate remainders
        logic finish;     // form the reduced result
    } ctl_t;

endpackage

FILE: sv/modular_inverse_prime_field_core.sv
`timescale 1ns / 1ps
// One word is in flight at a time; the next start can be taken in the done cycle.
// Each quotient bit uses an align step and a subtract step on the shared unit.
// Reset is asynchronous: sequencer idles, field_order returns to 7; done cannot be stalled.
// ----------------------------------------------------------------------------
// modular_inverse_prime_field_core: modular inverse by extended Euclid
// Computes operand_value^-1 mod field_order with a shift/subtract divider
// folded into the Euclid loop; reports has_inverse when the gcd is one.
// ----------------------------------------------------------------------------
module modular_inverse_prime_field_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [mipf_pkg::FIELD_BITS-1:0] operand_value,
    output logic                            done,
    output logic [mipf_pkg::FIELD_BITS-1:0] inverse_value,
    output logic                            has_inverse,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mipf_pkg::FIELD_BITS-1:0] cfg_data
);

    localparam int W = mipf_pkg::WORD_BITS;
    localparam int C = mipf_pkg::CNT_BITS;

    mipf_pkg::ctl_t  ctl;
    mipf_pkg::stat_t stat;

    logic [mipf_pkg::FIELD_BITS-1:0] field_order_reg;
    logic [W-1:0] rp_reg, rp_next;     // previous remainder / running dividend
    logic [W-1:0] rc_reg, rc_next;     // current remainder (divisor)
    logic [W-1:0] sp_reg, sp_next;     // previous coefficient / accumulator
    logic [W-1:0] sc_reg, sc_next;     // current coefficient
    logic         par_reg, par_next;   // sign parity of sp
    logic [W-1:0] d_reg, d_next;       // shifted divisor
    logic [W-1:0] e_reg, e_next;       // shifted coefficient
    logic [C-1:0] k_reg, k_next;       // quotient bit position
    logic         done_reg;
    logic [mipf_pkg::FIELD_BITS-1:0] inverse_value_reg, inverse_value_next;
    logic         has_inverse_reg, has_inverse_next;

    logic [W-1:0] m_w;
    logic [W-1:0] mag;
    logic [W:0]   alu_x, alu_y, alu_diff;
    logic         alu_borrow;
    logic [W-1:0] alu_sum;
    logic [W-1:0] rp_sub, sp_sub;
    logic         has_inv;
    logic [W-1:0] inv_w;

    assign m_w = W'(field_order_reg);

    // Configuration word: take it while idle
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_order_reg <= mipf_pkg::FIELD_ORDER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            field_order_reg <= cfg_data;
        end
    end

    mipf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    // Reduce the final coefficient: it never exceeds the modulus
    assign mag = (sp_reg == m_w) ? '0 : sp_reg;

    // Operand select for the shared unit
    always_comb
    begin
        alu_x = {1'b0, rp_reg};
        alu_y = {1'b0, d_reg};
        if (ctl.finish)
        begin
            alu_x = {1'b0, m_w};
            alu_y = {1'b0, mag};
        end
        else if (ctl.align)
        begin
            alu_y = {d_reg, 1'b0};
        end
    end

    mipf_alu u_alu (
        .x      (alu_x),
        .y      (alu_y),
        .u      (sp_reg),
        .v      (e_reg),
        .diff   (alu_diff),
        .borrow (alu_borrow),
        .sum    (alu_sum)
    );

    assign stat.rc_zero   = (rc_reg == '0);
    assign stat.can_shift = !alu_borrow;
    assign stat.k_zero    = (k_reg == '0);

    // Restoring subtract: keep the difference when the divisor fits
    assign rp_sub = alu_borrow ? rp_reg : alu_diff[W-1:0];
    assign sp_sub = alu_borrow ? sp_reg : alu_sum;

    // Result: inverse exists only for a unit gcd and nonzero modulus
    assign has_inv = (rp_reg == W'(1)) && (m_w != '0);
    assign inv_w   = (!par_reg || (mag == '0)) ? mag : alu_diff[W-1:0];

    // Datapath next values
    always_comb
    begin
        rp_next            = rp_reg;
        rc_next            = rc_reg;
        sp_next            = sp_reg;
        sc_next            = sc_reg;
        par_next           = par_reg;
        d_next             = d_reg;
        e_next             = e_reg;
        k_next             = k_reg;
        inverse_value_next = inverse_value_reg;
        has_inverse_next   = has_inverse_reg;
        if (ctl.load)
        begin
            rp_next  = W'(operand_value);
            rc_next  = m_w;
            sp_next  = W'(1);
            sc_next  = '0;
            par_next = 1'b0;
            d_next   = m_w;
            e_next   = '0;
            k_next   = '0;
        end
        else if (ctl.shift_up)
        begin
            d_next = {d_reg[W-2:0], 1'b0};
            e_next = {e_reg[W-2:0], 1'b0};
            k_next = k_reg + C'(1);
        end
        else if (ctl.swap)
        begin
            rp_next  = rc_reg;
            rc_next  = rp_sub;
            sp_next  = sc_reg;
            sc_next  = sp_sub;
            par_next = !par_reg;
            d_next   = rp_sub;
            e_next   = sp_sub;
            k_next   = '0;
        end
        else if (ctl.sub_step)
        begin
            rp_next = rp_sub;
            sp_next = sp_sub;
            d_next  = {1'b0, d_reg[W-1:1]};
            e_next  = {1'b0, e_reg[W-1:1]};
            k_next  = k_reg - C'(1);
        end
        else if (ctl.finish)
        begin
            has_inverse_next   = has_inv;
            inverse_value_next = has_inv ? mipf_pkg::FIELD_BITS'(inv_w) : '0;
        end
    end

    // Hold datapath and result words
    always_ff @(posedge clk)
    begin
        rp_reg            <= rp_next;
        rc_reg            <= rc_next;
        sp_reg            <= sp_next;
        sc_reg            <= sc_next;
        par_reg           <= par_next;
        d_reg             <= d_next;
        e_reg             <= e_next;
        k_reg             <= k_next;
        inverse_value_reg <= inverse_value_next;
        has_inverse_reg   <= has_inverse_next;
    end

    // Strobe the result word for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.finish;
        end
    end

    assign done          = done_reg;
    assign inverse_value = inverse_value_reg;
    assign has_inverse   = has_inverse_reg;

`ifndef SYNTHESIS
    // An accepted word keeps the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start accepted but block not busy");

    // No inverse means a zero result
    a_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !has_inverse) |-> (inverse_value == '0))
        else $error("nonzero result without inverse");

    // Result lies below the modulus
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (field_order_reg != '0)) |-> (inverse_value < field_order_reg))
        else $error("result not reduced");

    // Result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");
`endif

endmodule

FILE: sv/mipf_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipf_alu: shared subtract/compare and add unit
// One subtractor with borrow (also used as the magnitude compare) and one
// adder for the Bezout coefficient, reused by the align, subtract and finish steps.
// ----------------------------------------------------------------------------
module mipf_alu (
    input  logic [mipf_pkg::WORD_BITS:0]   x,
    input  logic [mipf_pkg::WORD_BITS:0]   y,
    input  logic [mipf_pkg::WORD_BITS-1:0] u,
    input  logic [mipf_pkg::WORD_BITS-1:0] v,
    output logic [mipf_pkg::WORD_BITS:0]   diff,
    output logic                           borrow,
    output logic [mipf_pkg::WORD_BITS-1:0] sum
);

    logic [mipf_pkg::WORD_BITS+1:0] diff_full;
    logic [mipf_pkg::WORD_BITS:0]   sum_full;

    // Subtract with borrow out; borrow high means y > x
    assign diff_full = {1'b0, x} - {1'b0, y};
    assign diff      = diff_full[mipf_pkg::WORD_BITS:0];
    assign borrow    = diff_full[mipf_pkg::WORD_BITS+1];

    // Coefficient accumulate; values stay below the modulus
    assign sum_full  = {1'b0, u} + {1'b0, v};
    assign sum       = sum_full[mipf_pkg::WORD_BITS-1:0];

endmodule

FILE: sv/mipf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipf_ctrl: sequencer for the extended Euclid loop
// Steps each division through an align phase (double the divisor) and a
// restoring subtract phase, then hands off to the result stage.
// ----------------------------------------------------------------------------
module mipf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  mipf_pkg::stat_t stat,
    output mipf_pkg::ctl_t  ctl,
    output logic            busy
);

    mipf_pkg::state_t state_reg;
    mipf_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mipf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mipf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mipf_pkg::ST_ALIGN;
                end
            end
            mipf_pkg::ST_ALIGN:
            begin
                if (stat.rc_zero)
                begin
                    state_next = mipf_pkg::ST_FINISH;
                end
                else if (!stat.can_shift)
                begin
                    state_next = mipf_pkg::ST_SUB;
                end
            end
            mipf_pkg::ST_SUB:
            begin
                if (stat.k_zero)
                begin
                    state_next = mipf_pkg::ST_ALIGN;
                end
            end
            mipf_pkg::ST_FINISH:
            begin
                state_next = mipf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mipf_pkg::ST_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        ctl  = '0;
        busy = 1'b1;
        unique case (state_reg)
            mipf_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                ctl.load = start;
            end
            mipf_pkg::ST_ALIGN:
            begin
                ctl.align    = 1'b1;
                ctl.shift_up = !stat.rc_zero && stat.can_shift;
            end
            mipf_pkg::ST_SUB:
            begin
                ctl.sub_step = 1'b1;
                ctl.swap     = stat.k_zero;
            end
            mipf_pkg::ST_FINISH:
            begin
                ctl.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A swap only closes a subtract phase
    a_swap_in_sub: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.swap |-> ctl.sub_step)
        else $error("swap outside subtract phase");

    // Finish lasts one cycle and frees the block
    a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> !busy)
        else $error("finish did not return to idle");

    // At most one of load, align, subtract and finish at a time
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.load, ctl.align, ctl.sub_step, ctl.finish}))
        else $error("overlapping datapath commands");
`endif

endmodule
